@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker of this block.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication in the same cycle.
`define CFOV_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle.
`define CFOV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cfov_pkg.sv @@
// Package for cell_face_outflux_volume: widths, face and register codes,
// and the fixed-point helper functions. No dependencies.
package cfov_pkg;

    localparam int FRAC_BITS = 16;

    localparam int WORD_W    = 32;
    localparam int WIDE_W    = 2 * WORD_W;
    localparam int DISP_W    = 31;
    localparam int PROD_W    = WIDE_W + 1;
    localparam int T_W       = WORD_W + 2;
    localparam int AREA_W    = WIDE_W - FRAC_BITS;
    localparam int AREA_LO_W = AREA_W / 2;
    localparam int AREA_HI_W = AREA_W - AREA_LO_W;
    localparam int PP_LO_W   = DISP_W + AREA_LO_W;
    localparam int PP_HI_W   = DISP_W + AREA_HI_W;
    localparam int VPROD_W   = DISP_W + AREA_W;
    localparam int VOL_W     = 48;
    localparam int TOT_W     = VOL_W + 3;
    localparam int CVLO_W    = AREA_LO_W + WORD_W;
    localparam int CVHI_W    = AREA_HI_W + WORD_W;
    localparam int CVPROD_W  = AREA_W + WORD_W;
    localparam int CV_W      = CVPROD_W - FRAC_BITS;
    localparam int CMP_W     = (CV_W > TOT_W) ? CV_W : TOT_W;
    localparam int NUM_FACES = 6;
    localparam int NUM_AXES  = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [WORD_W-1:0] CFG_RESET   = WORD_W'(1) << FRAC_BITS;
    localparam logic [DISP_W-1:0] DISP_CAP    = '1;
    localparam logic [VOL_W-1:0]  VOL_POS_CAP = {1'b0, {(VOL_W-1){1'b1}}};
    localparam logic [VOL_W-1:0]  VOL_NEG_CAP = {1'b1, {(VOL_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP   = 3'd0,
        REG_CELL_SIZE_X = 3'd1,
        REG_CELL_SIZE_Y = 3'd2,
        REG_CELL_SIZE_Z = 3'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        FACE_TOP    = 3'd0,
        FACE_BOTTOM = 3'd1,
        FACE_RIGHT  = 3'd2,
        FACE_LEFT   = 3'd3,
        FACE_FRONT  = 3'd4,
        FACE_BACK   = 3'd5
    } face_t;

    // Velocity inputs, in port order
    localparam int IN_X_LOW  = 0;
    localparam int IN_X_HIGH = 1;
    localparam int IN_Y_LOW  = 2;
    localparam int IN_Y_HIGH = 3;
    localparam int IN_Z_LOW  = 4;
    localparam int IN_Z_HIGH = 5;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    // Cross areas, one per pair of axes
    localparam int AREA_XZ = 0;
    localparam int AREA_YZ = 1;
    localparam int AREA_XY = 2;

    localparam int FACE_DISP_SEL [NUM_FACES] =
        '{IN_Y_HIGH, IN_Y_LOW, IN_X_HIGH, IN_X_LOW, IN_Z_HIGH, IN_Z_LOW};
    localparam int FACE_AREA_SEL [NUM_FACES] =
        '{AREA_XZ, AREA_XZ, AREA_YZ, AREA_YZ, AREA_XY, AREA_XY};

    typedef struct packed {
        logic [WORD_W-1:0] rx;
        logic [WORD_W-1:0] ry;
        logic [WORD_W-1:0] rz;
        logic [WORD_W-1:0] y_top;
        logic [WORD_W-1:0] y_bottom;
        logic [WORD_W-1:0] x_right;
        logic [WORD_W-1:0] x_left;
        logic [WORD_W-1:0] z_front;
        logic [WORD_W-1:0] z_back;
    } centroid_set_t;

    // Outward displacement from velocity * time step; low faces point the other way.
    function automatic logic [DISP_W-1:0] outward_disp(
        input logic signed [PROD_W-1:0] p,
        input logic                     high
    );
        logic signed [PROD_W:0] pos;
        logic [PROD_W:0]        shifted;
        pos = high ? (PROD_W+1)'(p) : -((PROD_W+1)'(p));
        shifted = pos[PROD_W:0] >> FRAC_BITS;
        if (pos[PROD_W] || pos == '0) begin
            return '0;
        end
        if (|shifted[PROD_W:DISP_W]) begin
            return DISP_CAP;
        end
        return shifted[DISP_W-1:0];
    endfunction

    // (a - b) / 2 rounded toward minus infinity
    function automatic logic [WORD_W-1:0] half_diff(
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b
    );
        logic signed [T_W-1:0] d;
        d = $signed(T_W'(a)) - $signed(T_W'(b));
        d = d >>> 1;
        return d[WORD_W-1:0];
    endfunction

    // Join the partial products, drop the fraction, saturate and apply the sign.
    function automatic logic signed [VOL_W-1:0] slab_volume(
        input logic [PP_LO_W-1:0] pp_lo,
        input logic [PP_HI_W-1:0] pp_hi,
        input logic               neg
    );
        logic [VPROD_W-1:0] full;
        logic [VPROD_W-1:0] shifted;
        logic [VOL_W-1:0]   cap;
        logic [VOL_W-1:0]   mag;
        full = (VPROD_W'(pp_hi) << AREA_LO_W) + VPROD_W'(pp_lo);
        shifted = full >> FRAC_BITS;
        cap = neg ? VOL_NEG_CAP : VOL_POS_CAP;
        mag = (shifted > VPROD_W'(cap)) ? cap : shifted[VOL_W-1:0];
        return neg ? VOL_W'(-mag) : mag;
    endfunction

endpackage

@@ rtl/cell_face_outflux_volume.sv @@
// Top level of cell_face_outflux_volume: eight-stage pipeline plus a
// six-entry output buffer. Depends on cfov_pkg.
//
//  channel   handshake                   payload
//  -------   -------------------------   -----------------------------------------
//  input     start high, busy low        vel_{x,y,z}_{low,high}
//  config    cfg_valid and cfg_ready     cfg_index, cfg_data
//  result    result_strobe, one cycle    face, flux_volume, centroid_*, exceeds_volume,
//                                        last
//
// A cell takes eight pipeline stages and then moves into the output buffer, which puts
// its six face results on the ports in consecutive cycles, top face first.
// New cells enter while earlier ones drain, but the single result port limits the rate;
// busy rises when the last stage holds a cell and the output buffer is still
// draining, and the whole pipeline then holds. Reset clears valids and sets all
// four registers to 1.0. cfg_ready is always high.
module cell_face_outflux_volume (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [cfov_pkg::WORD_W-1:0] vel_x_low,
    input  logic signed [cfov_pkg::WORD_W-1:0] vel_x_high,
    input  logic signed [cfov_pkg::WORD_W-1:0] vel_y_low,
    input  logic signed [cfov_pkg::WORD_W-1:0] vel_y_high,
    input  logic signed [cfov_pkg::WORD_W-1:0] vel_z_low,
    input  logic signed [cfov_pkg::WORD_W-1:0] vel_z_high,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cfov_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cfov_pkg::WORD_W-1:0]        cfg_data,
    output logic                               result_strobe,
    output logic [2:0]                         face,
    output logic signed [cfov_pkg::VOL_W-1:0]  flux_volume,
    output logic signed [cfov_pkg::WORD_W-1:0] centroid_x,
    output logic signed [cfov_pkg::WORD_W-1:0] centroid_y,
    output logic signed [cfov_pkg::WORD_W-1:0] centroid_z,
    output logic                               exceeds_volume,
    output logic                               last
);

    localparam int NF = cfov_pkg::NUM_FACES;
    localparam int NA = cfov_pkg::NUM_AXES;

    // Configuration registers
    logic [cfov_pkg::WORD_W-1:0] time_step_reg;
    logic [cfov_pkg::WORD_W-1:0] cell_size_x_reg;
    logic [cfov_pkg::WORD_W-1:0] cell_size_y_reg;
    logic [cfov_pkg::WORD_W-1:0] cell_size_z_reg;

    // Cell volume, recomputed continuously from the registers
    logic [cfov_pkg::WIDE_W-1:0]   cv_xy;
    logic [cfov_pkg::AREA_W-1:0]   cv_area_reg;
    logic [cfov_pkg::CVLO_W-1:0]   cv_lo_reg;
    logic [cfov_pkg::CVHI_W-1:0]   cv_hi_reg;
    logic [cfov_pkg::CVPROD_W-1:0] cv_sum;
    logic [cfov_pkg::CV_W-1:0]     cellvol_reg;

    // Pipeline control
    logic adv;
    logic accept;
    logic load;
    logic [8:1] valid_reg;

    // Stage payloads
    logic signed [cfov_pkg::WORD_W-1:0] vel [NF];
    logic signed [cfov_pkg::PROD_W-1:0] prod1_reg [NF];
    logic [cfov_pkg::DISP_W-1:0]        disp2_reg [NF];
    logic [cfov_pkg::DISP_W-1:0]        disp3_reg [NF];
    logic [cfov_pkg::DISP_W-1:0]        disp4_reg [NF];
    logic [cfov_pkg::WORD_W-1:0]        mag3_reg [NA];
    logic [NA-1:0]                      neg3_reg;
    logic [cfov_pkg::AREA_W-1:0]        area4_reg [NA];
    logic [NA-1:0]                      neg4_reg;
    logic [cfov_pkg::PP_LO_W-1:0]       pp_lo5_reg [NF];
    logic [cfov_pkg::PP_HI_W-1:0]       pp_hi5_reg [NF];
    logic [NF-1:0]                      neg5_reg;
    logic signed [cfov_pkg::VOL_W-1:0]  vol6_reg [NF];
    logic signed [cfov_pkg::VOL_W-1:0]  vol7_reg [NF];
    logic signed [cfov_pkg::VOL_W-1:0]  vol8_reg [NF];
    logic signed [cfov_pkg::TOT_W-1:0]  part7_reg [NA];
    logic signed [cfov_pkg::TOT_W-1:0]  total;
    logic                               exceed8_reg;
    cfov_pkg::centroid_set_t            cent3_reg;
    cfov_pkg::centroid_set_t            cent4_reg;
    cfov_pkg::centroid_set_t            cent5_reg;
    cfov_pkg::centroid_set_t            cent6_reg;
    cfov_pkg::centroid_set_t            cent7_reg;
    cfov_pkg::centroid_set_t            cent8_reg;

    // Stage 3 combinational values
    logic signed [cfov_pkg::T_W-1:0] rem [NA];
    logic [cfov_pkg::WORD_W-1:0]     d_left;
    logic [cfov_pkg::WORD_W-1:0]     d_right;
    logic [cfov_pkg::WORD_W-1:0]     d_bottom;
    logic [cfov_pkg::WORD_W-1:0]     d_top;
    logic [cfov_pkg::WORD_W-1:0]     d_back;
    logic [cfov_pkg::WORD_W-1:0]     d_front;

    // Output buffer
    logic                               obuf_valid_reg;
    cfov_pkg::face_t                    obuf_face_reg;
    logic [2:0]                         face_inc;
    logic signed [cfov_pkg::VOL_W-1:0]  obuf_vol_reg [NF];
    cfov_pkg::centroid_set_t            obuf_cent_reg;
    logic                               obuf_exceed_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg   <= cfov_pkg::CFG_RESET;
            cell_size_x_reg <= cfov_pkg::CFG_RESET;
            cell_size_y_reg <= cfov_pkg::CFG_RESET;
            cell_size_z_reg <= cfov_pkg::CFG_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cfov_pkg::REG_TIME_STEP:   time_step_reg   <= cfg_data;
                cfov_pkg::REG_CELL_SIZE_X: cell_size_x_reg <= cfg_data;
                cfov_pkg::REG_CELL_SIZE_Y: cell_size_y_reg <= cfg_data;
                cfov_pkg::REG_CELL_SIZE_Z: cell_size_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Cell volume: ((sx * sy) >> F) * sz >> F, the second product split in two
    assign cv_xy  = cfov_pkg::WIDE_W'(cell_size_x_reg) * cfov_pkg::WIDE_W'(cell_size_y_reg);
    assign cv_sum = (cfov_pkg::CVPROD_W'(cv_hi_reg) << cfov_pkg::AREA_LO_W)
                  + cfov_pkg::CVPROD_W'(cv_lo_reg);

    always_ff @(posedge clk)
    begin
        cv_area_reg <= cv_xy[cfov_pkg::WIDE_W-1:cfov_pkg::FRAC_BITS];
        cv_lo_reg   <= cfov_pkg::CVLO_W'(cv_area_reg[cfov_pkg::AREA_LO_W-1:0])
                     * cfov_pkg::CVLO_W'(cell_size_z_reg);
        cv_hi_reg   <= cfov_pkg::CVHI_W'(cv_area_reg[cfov_pkg::AREA_W-1:cfov_pkg::AREA_LO_W])
                     * cfov_pkg::CVHI_W'(cell_size_z_reg);
        // Saturate when the second product runs past 64 bits
        cellvol_reg <= (|cv_sum[cfov_pkg::CVPROD_W-1:cfov_pkg::WIDE_W])
                     ? {cfov_pkg::CV_W{1'b1}}
                     : cv_sum[cfov_pkg::CVPROD_W-1:cfov_pkg::FRAC_BITS];
    end

    // Hold the whole pipeline while the last stage waits for the buffer
    assign load   = valid_reg[8] && (!obuf_valid_reg || obuf_face_reg == cfov_pkg::FACE_BACK);
    assign adv    = !valid_reg[8] || load;
    assign busy   = !adv;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[7:1], accept};
        end
    end

    assign vel[cfov_pkg::IN_X_LOW]  = vel_x_low;
    assign vel[cfov_pkg::IN_X_HIGH] = vel_x_high;
    assign vel[cfov_pkg::IN_Y_LOW]  = vel_y_low;
    assign vel[cfov_pkg::IN_Y_HIGH] = vel_y_high;
    assign vel[cfov_pkg::IN_Z_LOW]  = vel_z_low;
    assign vel[cfov_pkg::IN_Z_HIGH] = vel_z_high;

    assign d_left   = cfov_pkg::WORD_W'(disp2_reg[cfov_pkg::IN_X_LOW]);
    assign d_right  = cfov_pkg::WORD_W'(disp2_reg[cfov_pkg::IN_X_HIGH]);
    assign d_bottom = cfov_pkg::WORD_W'(disp2_reg[cfov_pkg::IN_Y_LOW]);
    assign d_top    = cfov_pkg::WORD_W'(disp2_reg[cfov_pkg::IN_Y_HIGH]);
    assign d_back   = cfov_pkg::WORD_W'(disp2_reg[cfov_pkg::IN_Z_LOW]);
    assign d_front  = cfov_pkg::WORD_W'(disp2_reg[cfov_pkg::IN_Z_HIGH]);

    // Remaining widths, exact and signed
    assign rem[cfov_pkg::AXIS_X] = $signed(cfov_pkg::T_W'(cell_size_x_reg))
                                 - $signed(cfov_pkg::T_W'(d_right))
                                 - $signed(cfov_pkg::T_W'(d_left));
    assign rem[cfov_pkg::AXIS_Y] = $signed(cfov_pkg::T_W'(cell_size_y_reg))
                                 - $signed(cfov_pkg::T_W'(d_top))
                                 - $signed(cfov_pkg::T_W'(d_bottom));
    assign rem[cfov_pkg::AXIS_Z] = $signed(cfov_pkg::T_W'(cell_size_z_reg))
                                 - $signed(cfov_pkg::T_W'(d_front))
                                 - $signed(cfov_pkg::T_W'(d_back));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage 1: velocity times time step
            for (int k = 0; k < NF; k++)
            begin
                prod1_reg[k] <= $signed(vel[k]) * $signed({1'b0, time_step_reg});
            end

            // Stage 2: outward displacement, odd inputs are high faces
            for (int k = 0; k < NF; k++)
            begin
                disp2_reg[k] <= cfov_pkg::outward_disp(prod1_reg[k], k[0]);
            end

            // Stage 3: width magnitudes and signs, centroids
            for (int a = 0; a < NA; a++)
            begin
                mag3_reg[a] <= rem[a][cfov_pkg::T_W-1]
                             ? cfov_pkg::WORD_W'(-rem[a])
                             : cfov_pkg::WORD_W'(rem[a]);
                neg3_reg[a] <= rem[a][cfov_pkg::T_W-1];
            end
            disp3_reg          <= disp2_reg;
            cent3_reg.rx       <= cfov_pkg::half_diff(d_left, d_right);
            cent3_reg.ry       <= cfov_pkg::half_diff(d_bottom, d_top);
            cent3_reg.rz       <= cfov_pkg::half_diff(d_back, d_front);
            cent3_reg.y_top    <= cfov_pkg::half_diff(cell_size_y_reg, d_top);
            cent3_reg.y_bottom <= cfov_pkg::half_diff(d_bottom, cell_size_y_reg);
            cent3_reg.x_right  <= cfov_pkg::half_diff(cell_size_x_reg, d_right);
            cent3_reg.x_left   <= cfov_pkg::half_diff(d_left, cell_size_x_reg);
            cent3_reg.z_front  <= cfov_pkg::half_diff(cell_size_z_reg, d_front);
            cent3_reg.z_back   <= cfov_pkg::half_diff(d_back, cell_size_z_reg);

            // Stage 4: cross areas
            area4_reg[cfov_pkg::AREA_XZ] <= cfov_pkg::AREA_W'(
                (cfov_pkg::WIDE_W'(mag3_reg[cfov_pkg::AXIS_X])
               * cfov_pkg::WIDE_W'(mag3_reg[cfov_pkg::AXIS_Z])) >> cfov_pkg::FRAC_BITS);
            area4_reg[cfov_pkg::AREA_YZ] <= cfov_pkg::AREA_W'(
                (cfov_pkg::WIDE_W'(mag3_reg[cfov_pkg::AXIS_Y])
               * cfov_pkg::WIDE_W'(mag3_reg[cfov_pkg::AXIS_Z])) >> cfov_pkg::FRAC_BITS);
            area4_reg[cfov_pkg::AREA_XY] <= cfov_pkg::AREA_W'(
                (cfov_pkg::WIDE_W'(mag3_reg[cfov_pkg::AXIS_X])
               * cfov_pkg::WIDE_W'(mag3_reg[cfov_pkg::AXIS_Y])) >> cfov_pkg::FRAC_BITS);
            neg4_reg[cfov_pkg::AREA_XZ] <= neg3_reg[cfov_pkg::AXIS_X] ^ neg3_reg[cfov_pkg::AXIS_Z];
            neg4_reg[cfov_pkg::AREA_YZ] <= neg3_reg[cfov_pkg::AXIS_Y] ^ neg3_reg[cfov_pkg::AXIS_Z];
            neg4_reg[cfov_pkg::AREA_XY] <= neg3_reg[cfov_pkg::AXIS_X] ^ neg3_reg[cfov_pkg::AXIS_Y];
            disp4_reg <= disp3_reg;
            cent4_reg <= cent3_reg;

            // Stage 5: displacement times area, split into two partial products
            for (int f = 0; f < NF; f++)
            begin
                pp_lo5_reg[f] <= cfov_pkg::PP_LO_W'(disp4_reg[cfov_pkg::FACE_DISP_SEL[f]])
                    * cfov_pkg::PP_LO_W'(
                        area4_reg[cfov_pkg::FACE_AREA_SEL[f]][cfov_pkg::AREA_LO_W-1:0]);
                pp_hi5_reg[f] <= cfov_pkg::PP_HI_W'(disp4_reg[cfov_pkg::FACE_DISP_SEL[f]])
                    * cfov_pkg::PP_HI_W'(
                        area4_reg[cfov_pkg::FACE_AREA_SEL[f]]
                            [cfov_pkg::AREA_W-1:cfov_pkg::AREA_LO_W]);
                neg5_reg[f] <= neg4_reg[cfov_pkg::FACE_AREA_SEL[f]];
            end
            cent5_reg <= cent4_reg;

            // Stage 6: slab volumes
            for (int f = 0; f < NF; f++)
            begin
                vol6_reg[f] <= cfov_pkg::slab_volume(pp_lo5_reg[f], pp_hi5_reg[f], neg5_reg[f]);
            end
            cent6_reg <= cent5_reg;

            // Stage 7: pairwise sums
            for (int a = 0; a < NA; a++)
            begin
                part7_reg[a] <= cfov_pkg::TOT_W'(vol6_reg[2*a]) + cfov_pkg::TOT_W'(vol6_reg[2*a+1]);
            end
            vol7_reg  <= vol6_reg;
            cent7_reg <= cent6_reg;

            // Stage 8: total against cell volume
            exceed8_reg <= !total[cfov_pkg::TOT_W-1]
                && (cfov_pkg::CMP_W'(total[cfov_pkg::TOT_W-1:0])
                    > cfov_pkg::CMP_W'(cellvol_reg));
            vol8_reg  <= vol7_reg;
            cent8_reg <= cent7_reg;
        end
    end

    assign total = part7_reg[0] + part7_reg[1] + part7_reg[2];

    // Output buffer: emit one face per cycle
    assign face_inc = obuf_face_reg + 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obuf_valid_reg <= 1'b0;
            obuf_face_reg  <= cfov_pkg::FACE_TOP;
        end
        else
        begin
            if (load)
            begin
                obuf_valid_reg <= 1'b1;
                obuf_face_reg  <= cfov_pkg::FACE_TOP;
            end
            else if (obuf_valid_reg)
            begin
                if (obuf_face_reg == cfov_pkg::FACE_BACK)
                begin
                    obuf_valid_reg <= 1'b0;
                    obuf_face_reg  <= cfov_pkg::FACE_TOP;
                end
                else
                begin
                    obuf_face_reg <= cfov_pkg::face_t'(face_inc);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            obuf_vol_reg    <= vol8_reg;
            obuf_cent_reg   <= cent8_reg;
            obuf_exceed_reg <= exceed8_reg;
        end
    end

    always_comb
    begin
        centroid_x  = obuf_cent_reg.rx;
        centroid_y  = obuf_cent_reg.ry;
        centroid_z  = obuf_cent_reg.rz;
        flux_volume = obuf_vol_reg[0];
        unique case (obuf_face_reg)
            cfov_pkg::FACE_TOP:
            begin
                centroid_y  = obuf_cent_reg.y_top;
                flux_volume = obuf_vol_reg[0];
            end
            cfov_pkg::FACE_BOTTOM:
            begin
                centroid_y  = obuf_cent_reg.y_bottom;
                flux_volume = obuf_vol_reg[1];
            end
            cfov_pkg::FACE_RIGHT:
            begin
                centroid_x  = obuf_cent_reg.x_right;
                flux_volume = obuf_vol_reg[2];
            end
            cfov_pkg::FACE_LEFT:
            begin
                centroid_x  = obuf_cent_reg.x_left;
                flux_volume = obuf_vol_reg[3];
            end
            cfov_pkg::FACE_FRONT:
            begin
                centroid_z  = obuf_cent_reg.z_front;
                flux_volume = obuf_vol_reg[4];
            end
            cfov_pkg::FACE_BACK:
            begin
                centroid_z  = obuf_cent_reg.z_back;
                flux_volume = obuf_vol_reg[5];
            end
            default: ;
        endcase
    end

    assign result_strobe  = obuf_valid_reg;
    assign face           = obuf_face_reg;
    assign exceeds_volume = obuf_exceed_reg;
    assign last           = (obuf_face_reg == cfov_pkg::FACE_BACK);

endmodule

@@ rtl/cfov_checker.sv @@
// Port-level checker for cell_face_outflux_volume, bound to the top level.
// Depends on cfov_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cfov_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_strobe,
    input logic [2:0] face,
    input logic       exceeds_volume,
    input logic       last
);

    `CFOV_ASSERT_IMP(a_last_on_back, result_strobe, last == (face == cfov_pkg::FACE_BACK), "last mark not on back face")

    `CFOV_ASSERT_NEXT(a_faces_in_a_row, result_strobe && face != cfov_pkg::FACE_BACK, result_strobe && face == 3'($past(face) + 3'd1), "face results of a cell not consecutive")

    `CFOV_ASSERT_IMP(a_cell_starts_top, result_strobe && (!$past(result_strobe) || $past(face) == cfov_pkg::FACE_BACK), face == cfov_pkg::FACE_TOP, "cell results do not start at top face")

    `CFOV_ASSERT_IMP(a_flag_per_cell, result_strobe && face != cfov_pkg::FACE_TOP, exceeds_volume == $past(exceeds_volume), "volume flag changed within a cell")

endmodule

bind cell_face_outflux_volume cfov_checker u_cfov_checker (.*);

@@ sim/cell_face_outflux_volume_tb.sv @@
// Self-checking testbench for cell_face_outflux_volume: drives cells of six face velocities,
// predicts the six slab outflux results per cell and compares them as they stream out.
// Depends on cfov_pkg and the cell_face_outflux_volume RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [cfov_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd4;
    localparam logic [cfov_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef struct {
        logic signed [cfov_pkg::WORD_W-1:0] x_low;
        logic signed [cfov_pkg::WORD_W-1:0] x_high;
        logic signed [cfov_pkg::WORD_W-1:0] y_low;
        logic signed [cfov_pkg::WORD_W-1:0] y_high;
        logic signed [cfov_pkg::WORD_W-1:0] z_low;
        logic signed [cfov_pkg::WORD_W-1:0] z_high;
    } cell_vel_t;

    typedef struct {
        cfov_pkg::face_t                    face;
        logic signed [cfov_pkg::VOL_W-1:0]  volume;
        logic signed [cfov_pkg::WORD_W-1:0] cen_x;
        logic signed [cfov_pkg::WORD_W-1:0] cen_y;
        logic signed [cfov_pkg::WORD_W-1:0] cen_z;
        logic                               exceeds;
        logic                               last;
    } face_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [cfov_pkg::WORD_W-1:0] vel_x_low = '0;
    logic signed [cfov_pkg::WORD_W-1:0] vel_x_high = '0;
    logic signed [cfov_pkg::WORD_W-1:0] vel_y_low = '0;
    logic signed [cfov_pkg::WORD_W-1:0] vel_y_high = '0;
    logic signed [cfov_pkg::WORD_W-1:0] vel_z_low = '0;
    logic signed [cfov_pkg::WORD_W-1:0] vel_z_high = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [cfov_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [cfov_pkg::WORD_W-1:0] cfg_data = '0;
    logic result_strobe;
    logic [2:0] face;
    logic signed [cfov_pkg::VOL_W-1:0] flux_volume;
    logic signed [cfov_pkg::WORD_W-1:0] centroid_x;
    logic signed [cfov_pkg::WORD_W-1:0] centroid_y;
    logic signed [cfov_pkg::WORD_W-1:0] centroid_z;
    logic exceeds_volume;
    logic last;

    // Shadow copy of the block's registers
    logic [cfov_pkg::WORD_W-1:0] step_len = cfov_pkg::CFG_RESET;
    logic [cfov_pkg::WORD_W-1:0] size_x = cfov_pkg::CFG_RESET;
    logic [cfov_pkg::WORD_W-1:0] size_y = cfov_pkg::CFG_RESET;
    logic [cfov_pkg::WORD_W-1:0] size_z = cfov_pkg::CFG_RESET;

    cell_vel_t    pending_cells [$];
    face_result_t face_results_q [$];

    int  cells_submitted = 0;
    int  cells_accepted = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    int  sender_max_gap = 4;
    int  gap_left = 0;
    bit  cell_on_port = 1'b0;
    bit  cell_taken = 1'b0;
    bit  cfg_taken = 1'b0;

    cell_face_outflux_volume i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .vel_x_low      (vel_x_low),
        .vel_x_high     (vel_x_high),
        .vel_y_low      (vel_y_low),
        .vel_y_high     (vel_y_high),
        .vel_z_low      (vel_z_low),
        .vel_z_high     (vel_z_high),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_strobe  (result_strobe),
        .face           (face),
        .flux_volume    (flux_volume),
        .centroid_x     (centroid_x),
        .centroid_y     (centroid_y),
        .centroid_z     (centroid_z),
        .exceeds_volume (exceeds_volume),
        .last           (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // (a * b) >> FRAC_BITS, limited to cap; a product past 64 bits gives cap
    function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                   input logic [63:0] cap);
        logic [127:0] full;
        logic [63:0]  shifted;
        full = {64'd0, a} * {64'd0, b};
        if (full[127:64] != '0)
        begin
            return cap;
        end
        shifted = full[63:0] >> cfov_pkg::FRAC_BITS;
        return (shifted > cap) ? cap : shifted;
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [63:0] halve_down(input logic signed [63:0] d);
        return d >>> 1;
    endfunction

    // Outward face displacement: velocity times step, zero when pointing into the cell
    function automatic logic [63:0] face_shift(input logic signed [cfov_pkg::WORD_W-1:0] vel,
                                               input logic outward_high);
        logic signed [65:0] prod;
        logic [65:0]        m;
        prod = vel * $signed({1'b0, step_len});
        if (outward_high ? (prod <= 0) : (prod >= 0))
        begin
            return '0;
        end
        m = outward_high ? prod : -prod;
        m = m >> cfov_pkg::FRAC_BITS;
        return (m > 66'(cfov_pkg::DISP_CAP)) ? 64'(cfov_pkg::DISP_CAP) : m[63:0];
    endfunction

    // Magnitudes multiply, the sign of the two widths is applied at the end
    function automatic logic signed [63:0] slab_vol(input logic [63:0] disp,
                                                    input logic signed [63:0] wa,
                                                    input logic signed [63:0] wb);
        logic        neg;
        logic [63:0] area;
        logic [63:0] m;
        neg = (wa < 0) != (wb < 0);
        area = scaled_product(magnitude(wa), magnitude(wb), '1);
        m = scaled_product(disp, area,
                           neg ? 64'(cfov_pkg::VOL_NEG_CAP) : 64'(cfov_pkg::VOL_POS_CAP));
        return neg ? -m : m;
    endfunction

    function automatic void predict_cell_outflux(input logic signed [cfov_pkg::WORD_W-1:0] xl, xh,
                                                 input logic signed [cfov_pkg::WORD_W-1:0] yl, yh,
                                                 input logic signed [cfov_pkg::WORD_W-1:0] zl, zh);
        logic [63:0]        d_left, d_right, d_bottom, d_top, d_back, d_front;
        logic [63:0]        cell_vol;
        logic signed [63:0] sx, sy, sz, wx, wy, wz, rx, ry, rz, total;
        logic signed [63:0] vol [cfov_pkg::NUM_FACES];
        logic signed [63:0] cx [cfov_pkg::NUM_FACES];
        logic signed [63:0] cy [cfov_pkg::NUM_FACES];
        logic signed [63:0] cz [cfov_pkg::NUM_FACES];
        logic               over;
        face_result_t       res;
        d_left = face_shift(xl, 1'b0);
        d_right = face_shift(xh, 1'b1);
        d_bottom = face_shift(yl, 1'b0);
        d_top = face_shift(yh, 1'b1);
        d_back = face_shift(zl, 1'b0);
        d_front = face_shift(zh, 1'b1);
        sx = {32'd0, size_x};
        sy = {32'd0, size_y};
        sz = {32'd0, size_z};
        wx = sx - d_right - d_left;
        wy = sy - d_top - d_bottom;
        wz = sz - d_front - d_back;
        rx = halve_down(d_left - d_right);
        ry = halve_down(d_bottom - d_top);
        rz = halve_down(d_back - d_front);

        vol[cfov_pkg::FACE_TOP] = slab_vol(d_top, wx, wz);
        vol[cfov_pkg::FACE_BOTTOM] = slab_vol(d_bottom, wx, wz);
        vol[cfov_pkg::FACE_RIGHT] = slab_vol(d_right, wy, wz);
        vol[cfov_pkg::FACE_LEFT] = slab_vol(d_left, wy, wz);
        vol[cfov_pkg::FACE_FRONT] = slab_vol(d_front, wx, wy);
        vol[cfov_pkg::FACE_BACK] = slab_vol(d_back, wx, wy);

        cx[cfov_pkg::FACE_TOP] = rx;
        cy[cfov_pkg::FACE_TOP] = halve_down(sy - d_top);
        cz[cfov_pkg::FACE_TOP] = rz;
        cx[cfov_pkg::FACE_BOTTOM] = rx;
        cy[cfov_pkg::FACE_BOTTOM] = halve_down(d_bottom - sy);
        cz[cfov_pkg::FACE_BOTTOM] = rz;
        cx[cfov_pkg::FACE_RIGHT] = halve_down(sx - d_right);
        cy[cfov_pkg::FACE_RIGHT] = ry;
        cz[cfov_pkg::FACE_RIGHT] = rz;
        cx[cfov_pkg::FACE_LEFT] = halve_down(d_left - sx);
        cy[cfov_pkg::FACE_LEFT] = ry;
        cz[cfov_pkg::FACE_LEFT] = rz;
        cx[cfov_pkg::FACE_FRONT] = rx;
        cy[cfov_pkg::FACE_FRONT] = ry;
        cz[cfov_pkg::FACE_FRONT] = halve_down(sz - d_front);
        cx[cfov_pkg::FACE_BACK] = rx;
        cy[cfov_pkg::FACE_BACK] = ry;
        cz[cfov_pkg::FACE_BACK] = halve_down(d_back - sz);

        total = 0;
        for (int k = 0; k < cfov_pkg::NUM_FACES; k++)
        begin
            total += vol[k];
        end
        cell_vol = scaled_product(scaled_product(sx, sy, '1), sz, '1);
        over = (total > 0) && (total > cell_vol);

        for (int k = 0; k < cfov_pkg::NUM_FACES; k++)
        begin
            res.face = cfov_pkg::face_t'(k);
            res.volume = vol[k][cfov_pkg::VOL_W-1:0];
            res.cen_x = cx[k][cfov_pkg::WORD_W-1:0];
            res.cen_y = cy[k][cfov_pkg::WORD_W-1:0];
            res.cen_z = cz[k][cfov_pkg::WORD_W-1:0];
            res.exceeds = over;
            res.last = (k == cfov_pkg::FACE_BACK);
            face_results_q.push_back(res);
        end
    endfunction

    function automatic logic [cfov_pkg::WORD_W-1:0] draw_velocity();
        logic [cfov_pkg::WORD_W-1:0] m;
        case ($urandom_range(0, 9))
            0, 1: return $urandom();
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default:
            begin
                m = $urandom_range(0, 3 << cfov_pkg::FRAC_BITS);
                return $urandom_range(0, 1) ? -m : m;
            end
        endcase
    endfunction

    function automatic logic [cfov_pkg::WORD_W-1:0] draw_register();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0000;
            default: return $urandom_range(1 << (cfov_pkg::FRAC_BITS - 4),
                                           4 << cfov_pkg::FRAC_BITS);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic push_cell(input logic [cfov_pkg::WORD_W-1:0] xl, xh, yl, yh, zl, zh);
        cell_vel_t c;
        c.x_low = xl;
        c.x_high = xh;
        c.y_low = yl;
        c.y_high = yh;
        c.z_low = zl;
        c.z_high = zh;
        pending_cells.push_back(c);
        cells_submitted++;
    endtask

    task automatic push_random_cells(input int n);
        repeat (n)
        begin
            push_cell(draw_velocity(), draw_velocity(), draw_velocity(),
                      draw_velocity(), draw_velocity(), draw_velocity());
        end
    endtask

    // Saturating cases: everything at one extreme, then all faces outward at full speed
    task automatic push_extreme_cells();
        push_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    endtask

    task automatic wait_quiet();
        while (cells_accepted != cells_submitted || face_results_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_register(input logic [cfov_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [cfov_pkg::WORD_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        while (!cfg_taken)
        begin
            @(negedge clk);
        end
        cfg_taken = 1'b0;
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [cfov_pkg::WORD_W-1:0] ts, sx, sy, sz);
        write_register(cfov_pkg::REG_TIME_STEP, ts);
        write_register(cfov_pkg::REG_CELL_SIZE_X, sx);
        write_register(cfov_pkg::REG_CELL_SIZE_Y, sy);
        write_register(cfov_pkg::REG_CELL_SIZE_Z, sz);
    endtask

    // Register writes and cell transactions are taken at the same edge the block takes them
    always @(posedge clk)
    begin : accept_block
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cfov_pkg::REG_TIME_STEP:   step_len = cfg_data;
                    cfov_pkg::REG_CELL_SIZE_X: size_x = cfg_data;
                    cfov_pkg::REG_CELL_SIZE_Y: size_y = cfg_data;
                    cfov_pkg::REG_CELL_SIZE_Z: size_z = cfg_data;
                    default: ;
                endcase
                cfg_taken = 1'b1;
            end
            if (start && !busy)
            begin
                predict_cell_outflux(vel_x_low, vel_x_high, vel_y_low,
                                     vel_y_high, vel_z_low, vel_z_high);
                cells_accepted++;
                cell_taken = 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin : cell_driver
        cell_vel_t next_cell;
        if (rst_n)
        begin
            if (cell_taken)
            begin
                cell_taken = 1'b0;
                cell_on_port = 1'b0;
                gap_left = $urandom_range(0, sender_max_gap);
            end
            if (!cell_on_port)
            begin
                if (gap_left == 0 && pending_cells.size() > 0)
                begin
                    next_cell = pending_cells.pop_front();
                    vel_x_low <= next_cell.x_low;
                    vel_x_high <= next_cell.x_high;
                    vel_y_low <= next_cell.y_low;
                    vel_y_high <= next_cell.y_high;
                    vel_z_low <= next_cell.z_low;
                    vel_z_high <= next_cell.z_high;
                    cell_on_port = 1'b1;
                end
                else
                begin
                    // keep the payload moving while idle; the block must ignore it
                    if (gap_left > 0)
                    begin
                        gap_left--;
                    end
                    vel_x_low <= $urandom();
                    vel_x_high <= $urandom();
                    vel_y_low <= $urandom();
                    vel_y_high <= $urandom();
                    vel_z_low <= $urandom();
                    vel_z_high <= $urandom();
                end
            end
            start <= cell_on_port;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        face_result_t want;
        if (rst_n && result_strobe)
        begin
            if (face_results_q.size() == 0)
            begin
                report_mismatch("result with nothing outstanding", face, '0);
            end
            else
            begin
                want = face_results_q.pop_front();
                if (face !== want.face)
                    report_mismatch("face", face, want.face);
                if (flux_volume !== want.volume)
                    report_mismatch("flux_volume", flux_volume, want.volume);
                if (centroid_x !== want.cen_x)
                    report_mismatch("centroid_x", centroid_x, want.cen_x);
                if (centroid_y !== want.cen_y)
                    report_mismatch("centroid_y", centroid_y, want.cen_y);
                if (centroid_z !== want.cen_z)
                    report_mismatch("centroid_z", centroid_z, want.cen_z);
                if (exceeds_volume !== want.exceeds)
                    report_mismatch("exceeds_volume", exceeds_volume, want.exceeds);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[cell_face_outflux_volume] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings, all lengths 1.0
        sender_max_gap = 4;
        push_cell(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        push_extreme_cells();
        // one axis blown wide open, top face slab goes negative
        push_cell(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0000_4000, 32'h0, 32'h0);
        // single face beyond the cell: flag set with positive widths elsewhere
        push_cell(32'h0, 32'h0, 32'h0, 32'h0001_8000, 32'h0, 32'h0);
        push_cell(32'hFFFF_C000, 32'h0000_4000, 32'hFFFF_C000,
                  32'h0000_4000, 32'hFFFF_C000, 32'h0000_4000);
        // every face pointing inward
        push_cell(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000,
                  32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000);
        push_cell(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        push_cell(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        push_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cell(32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1);
        // widths exactly zero
        push_cell(32'hFFFF_8000, 32'h0000_8000, 32'hFFFF_8000,
                  32'h0000_8000, 32'hFFFF_8000, 32'h0000_8000);
        // odd differences exercise the round-down of the centroid halving
        push_cell(32'h0, 32'h3, 32'hFFFF_FFFB, 32'h3, 32'h0, 32'h7);
        push_random_cells(30);
        wait_quiet();

        configure(32'h0000_8000, 32'h0002_0000, 32'h0000_C000, 32'h0003_0000);
        sender_max_gap = 0;
        push_random_cells(30);
        wait_quiet();

        configure(32'h0, draw_register(), draw_register(), draw_register());
        sender_max_gap = 2;
        push_extreme_cells();
        push_random_cells(20);
        wait_quiet();

        configure('1, '1, '1, '1);
        sender_max_gap = 4;
        push_extreme_cells();
        push_random_cells(25);
        wait_quiet();

        configure(cfov_pkg::CFG_RESET, 32'h0, 32'h0, 32'h0);
        sender_max_gap = 1;
        push_extreme_cells();
        push_random_cells(25);
        wait_quiet();

        // writes to unmapped indexes must leave every register alone
        write_register(REG_UNMAPPED_LO, 32'h0);
        write_register(REG_UNMAPPED_HI, '1);
        sender_max_gap = 3;
        push_random_cells(20);
        wait_quiet();

        repeat (3)
        begin
            configure(draw_register(), draw_register(), draw_register(), draw_register());
            sender_max_gap = $urandom_range(0, 4);
            push_random_cells(12);
            wait_quiet();
        end

        // drain: room for a cell to pass the pipeline and emit its faces, with margin
        repeat (20) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("[cell_face_outflux_volume] OK");
        end
        else
        begin
            $display("[cell_face_outflux_volume] ERROR");
        end
        $finish;
    end

endmodule
